// ===== hdl/wcps_pkg.sv =====
// Package: constants, types and helpers for the wildcard class pattern search unit.
`timescale 1ns / 1ps
package wcps_pkg;

   localparam int PAT_MAX   = 32;
   localparam int PAT_IDX_W = $clog2(PAT_MAX);
   localparam int LEN_W     = $clog2(PAT_MAX + 1);
   localparam int POS_W     = 16;
   localparam logic [POS_W-1:0] TEXT_MAX = 16'hFFFF;

   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;

   localparam logic [1:0] STAT_MATCH = 2'd0;
   localparam logic [1:0] STAT_DONE  = 2'd1;
   localparam logic [1:0] STAT_BAD   = 2'd2;
   localparam logic [1:0] STAT_OVER  = 2'd3;

   localparam logic [1:0] BAND_NONE  = 2'd0;
   localparam logic [1:0] BAND_DIGIT = 2'd1;
   localparam logic [1:0] BAND_LOWER = 2'd2;
   localparam logic [1:0] BAND_UPPER = 2'd3;

   typedef enum logic [1:0] {
      OP_PAT,
      OP_PAT_NEW,
      OP_TEXT,
      OP_TEXT_NEW
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       last;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT_MATCH,
      ST_EMIT_DONE,
      ST_EMIT_BAD
   } back_state_type;

   typedef enum logic [2:0] {
      P_TOK,
      P_OPEN,
      P_LEAD,
      P_BODY,
      P_SKIP2,
      P_SKIP1
   } parse_state_type;

   function automatic logic [1:0] band_of(input logic [7:0] c);
      logic [1:0] b;
      b = BAND_NONE;
      if (c >= CH_0 && c <= CH_9) b = BAND_DIGIT;
      else if (c >= CH_LA && c <= CH_LZ) b = BAND_LOWER;
      else if (c >= CH_UA && c <= CH_UZ) b = BAND_UPPER;
      return b;
   endfunction

endpackage

// ===== hdl/wcps_if.sv =====
// Channel interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface wcps_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic       first;
   logic       last;
   modport source (output valid, kind, data_byte, first, last, input ready);
   modport sink (input valid, kind, data_byte, first, last, output ready);
endinterface

interface wcps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] position;
   logic        end_of_run;
   modport source (output valid, status, position, end_of_run, input ready);
   modport sink (input valid, status, position, end_of_run, output ready);
endinterface

// ===== hdl/wcps_front.sv =====
// Front end: accepts input transfers, classifies them and pushes them into the queue.
`timescale 1ns / 1ps
module wcps_front
   import wcps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   wcps_req_if.sink  req_chan,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   logic      hold_valid_ff, hold_valid_in;
   entry_type hold_ff, hold_in;
   op_type    op_cls;

   always_comb begin
      case ({req_chan.kind, req_chan.first})
         2'b00:   op_cls = OP_PAT;
         2'b01:   op_cls = OP_PAT_NEW;
         2'b10:   op_cls = OP_TEXT;
         default: op_cls = OP_TEXT_NEW;
      endcase
   end

   assign q_push         = hold_valid_ff && !q_full;
   assign q_entry        = hold_ff;
   assign req_chan.ready = !hold_valid_ff || !q_full;

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      if (q_push) hold_valid_in = 1'b0;
      if (req_chan.valid && req_chan.ready) begin
         hold_valid_in     = 1'b1;
         hold_in.op        = op_cls;
         hold_in.data_byte = req_chan.data_byte;
         hold_in.last      = req_chan.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) hold_valid_ff <= 1'b0;
      else hold_valid_ff <= hold_valid_in;
      hold_ff <= hold_in;
   end

endmodule

// ===== hdl/wcps_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module wcps_queue
   import wcps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   entry_type  slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = !wr_ff;
      if (pop) rd_in = !rd_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

// ===== hdl/wcps_back.sv =====
// Back end: pattern store, token parser sequencer, text window and result register.
`timescale 1ns / 1ps
module wcps_back
   import wcps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  entry_type q_head,
   output logic      q_pop,
   wcps_rsp_if.source rsp_chan
);

   back_state_type  state_ff, state_in;
   parse_state_type pst_ff, pst_in;

   logic [7:0]       store_ff [PAT_MAX];
   logic [7:0]       win_ff [PAT_MAX];
   logic [LEN_W-1:0] len_ff, len_in, tc_ff, tc_in, hi_ff, hi_in, fp_ff, fp_in, k_ff, k_in;
   logic             pat_over_ff, pat_over_in, dirty_ff, dirty_in, bad_ff, bad_in;
   logic [POS_W-1:0] pos_ff, pos_in, start_ff, start_in;
   logic             over_ff, over_in, abort_ff, abort_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in, mode_ff, mode_in;
   logic [7:0]       la0_ff, la0_in, la1_ff, la1_in, la2_ff, la2_in;
   logic [1:0]       pcnt_ff, pcnt_in;
   logic             ok_ff, ok_in, star_ff, star_in, neg_ff, neg_in, hit_ff, hit_in;
   logic             rv_ff, rv_in, reor_ff, reor_in;
   logic [1:0]       rstat_ff, rstat_in;
   logic [POS_W-1:0] rpos_ff, rpos_in;

   logic                 store_we, win_we, shift, consume, out_free, scan_done, v0, v2;
   logic [PAT_IDX_W-1:0] store_wa;
   logic [7:0]           rd_byte, c;
   logic                 is_range, elem_hit;
   logic [LEN_W-1:0]     len_eff;
   logic [POS_W-1:0]     pos_next;
   logic                 abort_eff;

   assign out_free  = !rv_ff || rsp_chan.ready;
   assign v0        = hi_ff < len_ff;
   assign v2        = (hi_ff + LEN_W'(2)) < len_ff;
   assign rd_byte   = store_ff[fp_ff[PAT_IDX_W-1:0]];
   assign c         = win_ff[start_ff[PAT_IDX_W-1:0] + k_ff[PAT_IDX_W-1:0]];
   assign scan_done = (state_ff == ST_SCAN) && (pst_ff == P_TOK) && !v0;
   assign is_range  = v2 && (la1_ff == CH_DASH) && (band_of(la0_ff) != BAND_NONE)
                      && (band_of(la2_ff) == band_of(la0_ff)) && (la0_ff <= la2_ff);
   assign elem_hit  = is_range ? (c >= la0_ff && c <= la2_ff) : (c == la0_ff);
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign len_eff   = (q_head.op == OP_PAT_NEW) ? '0 : len_ff;
   assign abort_eff = (q_head.op == OP_TEXT_NEW) ? 1'b0 : abort_ff;
   assign pos_next  = pos_ff + POS_W'(1);

   assign rsp_chan.valid      = rv_ff;
   assign rsp_chan.status     = rstat_ff;
   assign rsp_chan.position   = rpos_ff;
   assign rsp_chan.end_of_run = reor_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop && (q_head.op == OP_TEXT || q_head.op == OP_TEXT_NEW) && !abort_eff)
               state_in = dirty_ff ? ST_PRIME : ST_DECIDE;
         end
         ST_PRIME: begin
            if (pcnt_ff == 2'd2) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (!mode_ff) state_in = ST_DECIDE;
               else state_in = ok_ff ? ST_EMIT_MATCH : ST_EMIT_DONE;
            end
         end
         ST_DECIDE: begin
            if (bad_ff) state_in = ST_EMIT_BAD;
            else if (pos_ff < TEXT_MAX && pos_next >= POS_W'(tc_ff)) state_in = ST_PRIME;
            else state_in = ST_EMIT_DONE;
         end
         ST_EMIT_MATCH: begin
            if (out_free) state_in = ST_EMIT_DONE;
         end
         ST_EMIT_DONE: begin
            if (!last_ff || out_free) state_in = ST_IDLE;
         end
         ST_EMIT_BAD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pst_in = pst_ff;  len_in = len_ff;  tc_in = tc_ff;  hi_in = hi_ff;  fp_in = fp_ff;
      k_in = k_ff;  pat_over_in = pat_over_ff;  dirty_in = dirty_ff;  bad_in = bad_ff;
      pos_in = pos_ff;  start_in = start_ff;  over_in = over_ff;  abort_in = abort_ff;
      byte_in = byte_ff;  last_in = last_ff;  mode_in = mode_ff;
      pcnt_in = pcnt_ff;  ok_in = ok_ff;  star_in = star_ff;  neg_in = neg_ff;  hit_in = hit_ff;
      rstat_in = rstat_ff;  rpos_in = rpos_ff;  reor_in = reor_ff;
      rv_in = rv_ff && !rsp_chan.ready;
      store_we = 1'b0;  store_wa = len_eff[PAT_IDX_W-1:0];
      win_we = 1'b0;  consume = 1'b0;  shift = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               byte_in = q_head.data_byte;
               last_in = q_head.last;
               if (q_head.op == OP_PAT || q_head.op == OP_PAT_NEW) begin
                  dirty_in = 1'b1;
                  if (q_head.op == OP_PAT_NEW) pat_over_in = 1'b0;
                  if (len_eff < LEN_W'(PAT_MAX)) begin
                     store_we = 1'b1;
                     len_in   = len_eff + LEN_W'(1);
                  end else begin
                     len_in      = len_eff;
                     pat_over_in = 1'b1;
                  end
               end else begin
                  if (q_head.op == OP_TEXT_NEW) begin
                     pos_in   = '0;
                     over_in  = 1'b0;
                     abort_in = 1'b0;
                  end
                  mode_in = 1'b0;
                  fp_in   = '0;
                  hi_in   = '0;
                  pcnt_in = '0;
               end
            end
         end
         ST_PRIME: begin
            shift   = 1'b1;
            pcnt_in = pcnt_ff + 2'd1;
            pst_in  = P_TOK;
            k_in    = '0;
            ok_in   = 1'b1;
            star_in = 1'b0;
         end
         ST_SCAN: begin
            case (pst_ff)
               P_TOK: begin
                  if (scan_done) begin
                     if (!mode_ff) begin
                        tc_in    = k_ff;
                        bad_in   = (len_ff == '0) || pat_over_ff || star_ff;
                        dirty_in = 1'b0;
                     end
                  end else if (la0_ff == CH_LBRACK) begin
                     consume = 1'b1;
                     neg_in  = 1'b0;
                     hit_in  = 1'b0;
                     pst_in  = P_OPEN;
                  end else begin
                     consume = 1'b1;
                     if (la0_ff == CH_STAR) star_in = 1'b1;
                     k_in  = k_ff + LEN_W'(1);
                     ok_in = ok_ff && (la0_ff == CH_QUEST || la0_ff == c);
                  end
               end
               P_OPEN, P_LEAD, P_BODY: begin
                  if (pst_ff == P_OPEN && v0 && la0_ff == CH_CARET) begin
                     consume = 1'b1;
                     neg_in  = 1'b1;
                     pst_in  = P_LEAD;
                  end else if (!v0 || (pst_ff == P_BODY && la0_ff == CH_RBRACK)) begin
                     // token ends: closing bracket or end of pattern
                     consume = v0;
                     k_in    = k_ff + LEN_W'(1);
                     ok_in   = ok_ff && (hit_ff != neg_ff);
                     pst_in  = P_TOK;
                  end else begin
                     consume = 1'b1;
                     hit_in  = hit_ff || elem_hit;
                     pst_in  = is_range ? P_SKIP2 : P_BODY;
                  end
               end
               P_SKIP2: begin
                  consume = 1'b1;
                  pst_in  = P_SKIP1;
               end
               P_SKIP1: begin
                  consume = 1'b1;
                  pst_in  = P_BODY;
               end
               default: pst_in = P_TOK;
            endcase
            shift = consume;
            if (consume) hi_in = hi_ff + LEN_W'(1);
         end
         ST_DECIDE: begin
            if (bad_ff) begin
               abort_in = 1'b1;
            end else if (pos_ff < TEXT_MAX) begin
               win_we  = 1'b1;
               pos_in  = pos_next;
               start_in = pos_next - POS_W'(tc_ff);
               mode_in = 1'b1;
               fp_in   = '0;
               hi_in   = '0;
               pcnt_in = '0;
            end else begin
               over_in = 1'b1;
            end
         end
         ST_EMIT_MATCH: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rstat_in = STAT_MATCH;
               rpos_in  = start_ff;
               reor_in  = !last_ff;
            end
         end
         ST_EMIT_DONE: begin
            if (last_ff && out_free) begin
               rv_in    = 1'b1;
               rstat_in = over_ff ? STAT_OVER : STAT_DONE;
               rpos_in  = pos_ff;
               reor_in  = 1'b1;
            end
         end
         ST_EMIT_BAD: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rstat_in = STAT_BAD;
               rpos_in  = '0;
               reor_in  = 1'b1;
            end
         end
         default: ;
      endcase

      la0_in = shift ? la1_ff : la0_ff;
      la1_in = shift ? la2_ff : la1_ff;
      la2_in = shift ? rd_byte : la2_ff;
      if (shift) fp_in = fp_ff + LEN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pst_ff      <= P_TOK;
         len_ff      <= '0;
         tc_ff       <= '0;
         pat_over_ff <= 1'b0;
         dirty_ff    <= 1'b0;
         bad_ff      <= 1'b1;
         pos_ff      <= '0;
         over_ff     <= 1'b0;
         abort_ff    <= 1'b0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pst_ff      <= pst_in;
         len_ff      <= len_in;
         tc_ff       <= tc_in;
         pat_over_ff <= pat_over_in;
         dirty_ff    <= dirty_in;
         bad_ff      <= bad_in;
         pos_ff      <= pos_in;
         over_ff     <= over_in;
         abort_ff    <= abort_in;
         rv_ff       <= rv_in;
      end
      hi_ff    <= hi_in;
      fp_ff    <= fp_in;
      k_ff     <= k_in;
      start_ff <= start_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      mode_ff  <= mode_in;
      la0_ff   <= la0_in;
      la1_ff   <= la1_in;
      la2_ff   <= la2_in;
      pcnt_ff  <= pcnt_in;
      ok_ff    <= ok_in;
      star_ff  <= star_in;
      neg_ff   <= neg_in;
      hit_ff   <= hit_in;
      rstat_ff <= rstat_in;
      rpos_ff  <= rpos_in;
      reor_ff  <= reor_in;
      if (store_we) store_ff[store_wa] <= q_head.data_byte;
      if (win_we) win_ff[pos_ff[PAT_IDX_W-1:0]] <= byte_ff;
   end

endmodule

// ===== hdl/wildcard_class_pattern_search_unit.sv =====
// Top level of the wildcard class pattern search unit.
//
//   channel   dir   transfer when          payload
//   req_chan  in    valid && ready         kind, data_byte, first, last
//   rsp_chan  out   valid && ready         status, position, end_of_run
//
// A pattern byte or an aborted text byte is taken by the back end in its idle state. A text
// byte with a bad pattern or no complete match window yet passes pop, decide, and done or
// error. Otherwise it adds priming, a scan over each pattern byte, each unterminated class
// and a final step, and a match transfer state if it matches. The first text byte
// after a pattern change adds a prime and a scan to count tokens. A stalled rsp_chan
// holds the back end; the front register and a two-entry queue keep taking input until they fill.
// Reset is synchronous, active high; the pattern counts as bad until one is loaded.
`timescale 1ns / 1ps
module wildcard_class_pattern_search_unit
   import wcps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wcps_req_if.sink   req_chan,
   wcps_rsp_if.source rsp_chan
);

   logic      q_full, q_push, q_empty, q_pop;
   entry_type q_entry, q_head;

   wcps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   wcps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   wcps_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/wildcard_class_pattern_search_unit_tb.sv =====
// Testbench: directed and random pattern/text streams checked against a built-in search predictor.
`timescale 1ns / 1ps
module wildcard_class_pattern_search_unit_tb
   import wcps_pkg::*;
();

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] position;
      logic        end_of_run;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;

   wcps_req_if req_chan ();
   wcps_rsp_if rsp_chan ();

   wildcard_class_pattern_search_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]  pat_mem [PAT_MAX];
   int          pat_len = 0;
   logic [7:0]  win_mem [PAT_MAX];
   int unsigned text_pos = 0;
   bit          pat_bad = 1'b1;
   bit          text_abort = 1'b0;
   bit          pat_over = 1'b0;
   bit          text_over = 1'b0;
   int          tok_count = 0;
   result_type  expected_results [$];

   function automatic logic [1:0] char_band(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return BAND_DIGIT;
      if (c >= CH_LA && c <= CH_LZ) return BAND_LOWER;
      if (c >= CH_UA && c <= CH_UZ) return BAND_UPPER;
      return BAND_NONE;
   endfunction

   // walks one class token from idx (at '['); returns membership of c
   function automatic bit class_hit(inout int idx, input logic [7:0] c);
      int i;
      bit neg, hit, lead;
      logic [1:0] b;
      i = idx + 1;
      neg = 0; hit = 0; lead = 1;
      if (i < pat_len && pat_mem[i] == CH_CARET) begin
         neg = 1;
         i++;
      end
      while (i < pat_len && (lead || pat_mem[i] != CH_RBRACK)) begin
         b = char_band(pat_mem[i]);
         lead = 0;
         if (i + 2 < pat_len && pat_mem[i+1] == CH_DASH && b != BAND_NONE &&
             char_band(pat_mem[i+2]) == b && pat_mem[i] <= pat_mem[i+2]) begin
            if (c >= pat_mem[i] && c <= pat_mem[i+2]) hit = 1;
            i += 3;
         end else begin
            if (c == pat_mem[i]) hit = 1;
            i++;
         end
      end
      if (i < pat_len && pat_mem[i] == CH_RBRACK) i++;
      idx = i;
      return hit != neg;
   endfunction

   function automatic void count_tokens();
      int i, w;
      bit star, dummy;
      i = 0; w = 0; star = 0;
      while (i < pat_len) begin
         if (pat_mem[i] == CH_LBRACK) dummy = class_hit(i, 8'h00);
         else begin
            if (pat_mem[i] == CH_STAR) star = 1;
            i++;
         end
         w++;
      end
      tok_count = w;
      pat_bad = (pat_len == 0) || pat_over || star;
   endfunction

   function automatic bit window_matches(input int unsigned start);
      int i, k;
      logic [7:0] c, t;
      i = 0; k = 0;
      while (i < pat_len) begin
         c = win_mem[(start + k) % PAT_MAX];
         t = pat_mem[i];
         if (t == CH_QUEST) i++;
         else if (t == CH_LBRACK) begin
            if (!class_hit(i, c)) return 0;
         end else begin
            if (t != c) return 0;
            i++;
         end
         k++;
      end
      return 1;
   endfunction

   function automatic void predict_search(bit kind, logic [7:0] b, bit first, bit last);
      result_type r [$];
      int unsigned start;
      if (!kind) begin
         if (first) begin
            pat_len = 0;
            pat_over = 0;
         end
         if (pat_len < PAT_MAX) pat_mem[pat_len++] = b;
         else pat_over = 1;
         count_tokens();
         return;
      end
      if (first) begin
         text_pos = 0;
         text_over = 0;
         text_abort = 0;
      end
      if (text_abort) return;
      if (pat_bad) begin
         text_abort = 1;
         expected_results.push_back('{STAT_BAD, 16'd0, 1'b1});
         return;
      end
      if (text_pos < 65535) begin
         win_mem[text_pos % PAT_MAX] = b;
         text_pos++;
         if (text_pos >= tok_count) begin
            start = text_pos - tok_count;
            if (window_matches(start)) r.push_back('{STAT_MATCH, start[15:0], 1'b0});
         end
      end else text_over = 1;
      if (last)
         r.push_back('{text_over ? STAT_OVER : STAT_DONE,
                       (text_pos > 65535) ? 16'hFFFF : text_pos[15:0], 1'b0});
      if (r.size() > 0) r[r.size()-1].end_of_run = 1'b1;
      foreach (r[j]) expected_results.push_back(r[j]);
   endfunction

   // driver
   initial begin
      req_chan.valid = 0;
      req_chan.kind = 0;
      req_chan.data_byte = 0;
      req_chan.first = 0;
      req_chan.last = 0;
      rsp_chan.ready = 0;
   end

   // valid stays high between back-to-back transfers; it drops only for an idle gap
   task automatic send_byte(bit kind, logic [7:0] b, bit first, bit last);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind <= kind;
      req_chan.data_byte <= b;
      req_chan.first <= first;
      req_chan.last <= last;
      do @(posedge clock); while (!req_chan.ready);
      predict_search(kind, b, first, last);
   endtask

   task automatic load_pattern(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i], i == 0, 1'b0);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(1'b1, s[i], i == 0, i == s.len() - 1);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (expected_results.size() > 0 && guard < 100000);
   endtask

   // result checker with random receiver stalls
   initial begin
      result_type exp_r;
      int stall;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected transfer status=%0d pos=%0d eor=%0b", $time,
                     rsp_chan.status, rsp_chan.position, rsp_chan.end_of_run);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_chan.status !== exp_r.status) begin
               $display("%0t: status exp %0d got %0d", $time, exp_r.status, rsp_chan.status);
               errors++;
            end
            if (rsp_chan.position !== exp_r.position) begin
               $display("%0t: position exp %0d got %0d", $time, exp_r.position,
                        rsp_chan.position);
               errors++;
            end
            if (rsp_chan.end_of_run !== exp_r.end_of_run) begin
               $display("%0t: end_of_run exp %0b got %0b", $time, exp_r.end_of_run,
                        rsp_chan.end_of_run);
               errors++;
            end
         end
      end
   end

   task automatic test_bad_patterns();
      send_text("ab");               // no pattern yet
      send_byte(1'b0, 8'h00, 1'b1, 1'b0);
      send_text("x");                // nul is a valid literal
      load_pattern("a*b");
      send_text("ab");
      load_pattern("0123456789abcdefghijklmnopqrstuvw"); // 33 bytes: overflow
      send_text("0123");
      send_byte(1'b1, 8'hFF, 1'b0, 1'b1); // aborted text stays silent
   endtask

   task automatic test_classes();
      load_pattern("a?[^]x-z]");
      send_text("abqazzab]");
      load_pattern("[]0-9][a-]");
      send_text("]5a-b0-");
      load_pattern("[?*][9-0A-Zb");   // unterminated class, reversed range
      send_text("*9bQ?-Ab");
      load_pattern("[^");
      send_byte(1'b1, 8'hFF, 1'b1, 1'b0);
      send_byte(1'b1, 8'h00, 1'b0, 1'b1);
      send_byte(1'b1, 8'h5E, 1'b0, 1'b1); // continues after last
   endtask

   task automatic test_pattern_switch();
      load_pattern("aa");
      send_byte(1'b1, "a", 1'b1, 1'b0);
      send_byte(1'b1, "a", 1'b0, 1'b0);
      load_pattern("a?a");           // new pattern mid-text
      send_byte(1'b1, "a", 1'b0, 1'b1);
      drain();                       // sender holds off until all results are back
   endtask

   function automatic logic [7:0] rand_pat_char();
      case ($urandom_range(0, 9))
         0: return CH_QUEST;
         1: return CH_LBRACK;
         2: return CH_RBRACK;
         3: return CH_CARET;
         4: return CH_DASH;
         5: return ($urandom_range(0, 15) == 0) ? CH_STAR : "b";
         6: return 8'($urandom_range(0, 255));
         default: return "a" + 8'($urandom_range(0, 2));
      endcase
   endfunction

   task automatic test_random_search();
      int n, len;
      for (int p = 0; p < 40; p++) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 5);
         for (int i = 0; i < len; i++) send_byte(1'b0, rand_pat_char(), i == 0, 1'b0);
         n = $urandom_range(5, 40);
         for (int i = 0; i < n; i++)
            send_byte(1'b1, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                            : "a" + 8'($urandom_range(0, 2)),
                      i == 0 || $urandom_range(0, 40) == 0,
                      i == n - 1 || $urandom_range(0, 30) == 0);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bad_patterns();
      test_classes();
      test_pattern_switch();
      test_random_search();
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
